// ===== sv/base64_stream_decoder_core_defines.svh =====
// Assertion helpers used by the decoder's output serializer.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

// Invariant: expr holds at every edge.
`define B64D_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication.
`define B64D_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B64D_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
package b64d_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CntExtW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int SumW = CntExtW + 1;
  localparam int MaxResults = 4;

  localparam logic [7:0] SKIP_CODE = 8'd255;
  localparam logic [7:0] PAD_CODE = 8'd254;

  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
  localparam logic REG_OUTPUT_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_e;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] count;
  } result_t;

  // Results caused by one character, in delivery order.
  typedef struct packed {
    result_t [MaxResults-1:0] entries;
    logic [2:0]               num;
  } bundle_t;

  // Map a character through the standard alphabet; skip and pad get codes of their own.
  function automatic logic [7:0] sextet_of(input logic [7:0] ch);
    logic [7:0] v;
    v = SKIP_CODE;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = ch - 8'h41;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = ch - 8'd71;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = ch + 8'd4;
    end else if (ch == 8'h2B) begin
      v = 8'd62;
    end else if (ch == 8'h2F) begin
      v = 8'd63;
    end else if (ch == 8'h3D) begin
      v = PAD_CODE;
    end
    return v;
  endfunction

  function automatic logic [15:0] count_low(input count_t c);
    logic [CntExtW-1:0] e;
    e = CntExtW'(c);
    return e[15:0];
  endfunction

endpackage

// ===== sv/b64d_decode.sv =====
module b64d_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          char_i,
  input  logic                fend_i,
  input  logic                advance_i,
  input  logic [15:0]         capacity_i,
  output b64d_pkg::bundle_t   bundle_o
);

  logic [23:0]          acc_q, acc_d;
  logic [1:0]           sext_q, sext_d;
  logic [2:0]           pad_q, pad_d;
  b64d_pkg::count_t     be_q, be_d;
  logic                 halt_q, halt_d;

  logic [7:0]           v;
  logic                 is_pad, active, group, ovf, emit, done;
  logic [2:0]           pad_n;
  logic [23:0]          acc_n;
  logic [1:0]           nb;
  logic [b64d_pkg::SumW-1:0] sum;
  b64d_pkg::count_t     be_after;
  logic [2:0]           n_bytes;
  logic [7:0]           byte_data [b64d_pkg::MaxResults];
  b64d_pkg::count_t     byte_cnt  [b64d_pkg::MaxResults];

  always_comb begin
    v       = b64d_pkg::sextet_of(char_i);
    is_pad  = (v == b64d_pkg::PAD_CODE);
    active  = !halt_q && (v != b64d_pkg::SKIP_CODE);
    pad_n   = pad_q + {2'b00, (is_pad && pad_q != 3'd7)};
    acc_n   = {acc_q[17:0], (is_pad ? 6'd0 : v[5:0])};
    group   = active && (sext_q == 2'd3);
    nb      = (pad_n >= 3'd2) ? 2'd1 : (2'd3 - pad_n[1:0]);
    sum     = b64d_pkg::SumW'(be_q) + b64d_pkg::SumW'(nb);
    ovf     = group && (sum > b64d_pkg::SumW'(capacity_i));
    emit    = group && !ovf;
    be_after = emit ? (be_q + b64d_pkg::count_t'(nb)) : be_q;
    n_bytes = emit ? {1'b0, nb} : 3'd0;
    done    = fend_i && !halt_q && !ovf;

    byte_data[0] = acc_n[23:16];
    byte_data[1] = acc_n[15:8];
    byte_data[2] = acc_n[7:0];
    byte_data[3] = 8'd0;
    byte_cnt[0]  = be_q + b64d_pkg::count_t'(1);
    byte_cnt[1]  = be_q + b64d_pkg::count_t'(2);
    byte_cnt[2]  = be_q + b64d_pkg::count_t'(3);
    byte_cnt[3]  = be_q;
  end

  always_comb begin
    for (int k = 0; k < b64d_pkg::MaxResults; k++) begin
      bundle_o.entries[k].kind  = b64d_pkg::KIND_BYTE;
      bundle_o.entries[k].data  = 8'd0;
      bundle_o.entries[k].count = 16'd0;
      if (ovf && k == 0) begin
        bundle_o.entries[k].kind  = b64d_pkg::KIND_OVERFLOW;
        bundle_o.entries[k].count = b64d_pkg::count_low(be_q);
      end else if (emit && (3'(k) < {1'b0, nb})) begin
        bundle_o.entries[k].data  = byte_data[k];
        bundle_o.entries[k].count = b64d_pkg::count_low(byte_cnt[k]);
      end else if (done && (3'(k) == n_bytes)) begin
        bundle_o.entries[k].kind  = b64d_pkg::KIND_DONE;
        bundle_o.entries[k].count = b64d_pkg::count_low(be_after);
      end
    end
    bundle_o.num = n_bytes + {2'b00, ovf} + {2'b00, done};
  end

  always_comb begin
    acc_d  = acc_q;
    sext_d = sext_q;
    pad_d  = pad_q;
    be_d   = be_after;
    halt_d = halt_q || ovf;
    if (group) begin
      acc_d  = 24'd0;
      sext_d = 2'd0;
      pad_d  = 3'd0;
    end else if (active) begin
      acc_d  = acc_n;
      sext_d = sext_q + 2'd1;
      pad_d  = pad_n;
    end
    // frame end wipes everything, overflow included
    if (fend_i) begin
      acc_d  = 24'd0;
      sext_d = 2'd0;
      pad_d  = 3'd0;
      be_d   = '0;
      halt_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 24'd0;
      sext_q <= 2'd0;
      pad_q  <= 3'd0;
      be_q   <= '0;
      halt_q <= 1'b0;
    end else if (advance_i) begin
      acc_q  <= acc_d;
      sext_q <= sext_d;
      pad_q  <= pad_d;
      be_q   <= be_d;
      halt_q <= halt_d;
    end
  end

endmodule

// ===== sv/b64d_serializer.sv =====
`include "base64_stream_decoder_core_defines.svh"

module b64d_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  b64d_pkg::bundle_t bundle_i,
  output logic              take_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        data_byte_o,
  output logic [15:0]       byte_count_o,
  output logic              last_of_run_o
);

  b64d_pkg::bundle_t bundle_q;
  logic              valid_q, valid_d;
  logic [1:0]        idx_q, idx_d;
  logic              last;
  b64d_pkg::result_t cur;

  assign cur  = bundle_q.entries[idx_q];
  assign last = ((3'(idx_q) + 3'd1) == bundle_q.num);

  assign take_ready_o  = !valid_q || (out_ready_i && last);
  assign out_valid_o   = valid_q;
  assign kind_o        = cur.kind;
  assign data_byte_o   = cur.data;
  assign byte_count_o  = cur.count;
  assign last_of_run_o = last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i && take_ready_o) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end else if (valid_q && out_ready_i) begin
      // advance, or drain when the last result leaves
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && take_ready_o) begin
      bundle_q <= bundle_i;
    end
  end

  `B64D_ASSERT(valid_has_entries, !valid_q || (bundle_q.num != 3'd0), "empty bundle shown")
  `B64D_ASSERT_IMP(index_in_range, valid_q, 3'(idx_q) < bundle_q.num, "result index overrun")
  `B64D_ASSERT_NXT(index_steps, valid_q && out_ready_i && !last,
                   valid_q && (idx_q == $past(idx_q) + 2'd1), "result index did not step")
  `B64D_ASSERT_NXT(load_restarts, load_i && take_ready_o, valid_q && (idx_q == 2'd0),
                   "new bundle not started at first result")

endmodule

// ===== sv/base64_stream_decoder_core.sv =====
// A character is registered at acceptance; its results are then registered in
// the output serializer when it can take them. Throughput: one character per
// cycle while each yields at most one result and out_ready_i is high; results
// beyond one stall input; the serializer sends one per cycle. Reset (async, active
// low) clears frame state and pending results and sets output_capacity to 65535.
module base64_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_count_o,
  output logic        last_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              in_valid_q;
  logic [7:0]        char_q;
  logic              fend_q;
  logic [15:0]       cap_q;
  logic              take_ready;
  logic              advance;
  b64d_pkg::bundle_t bundle;

  assign advance    = in_valid_q && take_ready;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      fend_q <= frame_end_i;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == b64d_pkg::REG_OUTPUT_CAPACITY) ? {16'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= b64d_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == b64d_pkg::REG_OUTPUT_CAPACITY) begin
      cap_q <= pwdata[15:0];
    end
  end

  b64d_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_i     (char_q),
    .fend_i     (fend_q),
    .advance_i  (advance),
    .capacity_i (cap_q),
    .bundle_o   (bundle)
  );

  b64d_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && (bundle.num != 3'd0)),
    .bundle_i      (bundle),
    .take_ready_o  (take_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .byte_count_o  (byte_count_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
